[rtl/vmt_pkg.sv]
// Shared types and widths for the vector move-towards pipeline.
// No dependencies; used by vmt_sqrt, vmt_div and vector_move_towards.
package vmt_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned MagW   = CoordW + 1;
    localparam int unsigned StepW  = 31;
    localparam int unsigned RadW   = 2 * MagW;
    localparam int unsigned NumW   = MagW + StepW;

    // side data carried alongside the square root
    typedef struct packed {
        logic [MagW-1:0]          adx;
        logic [MagW-1:0]          ady;
        logic                     sx;
        logic                     sy;
        logic signed [CoordW-1:0] cx;
        logic signed [CoordW-1:0] cy;
        logic signed [CoordW-1:0] tx;
        logic signed [CoordW-1:0] ty;
        logic [StepW-1:0]         step;
    } t_sq_pay;

    // side data carried alongside the x-axis divider
    typedef struct packed {
        logic                     reached;
        logic                     sx;
        logic signed [CoordW-1:0] cx;
        logic signed [CoordW-1:0] cy;
        logic signed [CoordW-1:0] tx;
        logic signed [CoordW-1:0] ty;
    } t_dx_pay;

endpackage

[rtl/vmt_sqrt.sv]
// Pipelined integer square root, one root bit per register stage.
// Depends on vmt_pkg for the radicand and root widths.
module vmt_sqrt
    import vmt_pkg::*;
#(
    parameter int unsigned PW = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [RadW-1:0]    i_rad,
    input  logic [PW-1:0]      i_pay,
    output logic               o_valid,
    output logic [MagW-1:0]    o_root,
    output logic [PW-1:0]      o_pay
);

    localparam int unsigned NStg = MagW;
    localparam int unsigned RemW = MagW + 5;

    logic              r_valid [0:NStg];
    logic [RadW-1:0]   r_rad   [0:NStg];
    logic [RemW-1:0]   r_rem   [0:NStg];
    logic [MagW-1:0]   r_root  [0:NStg];
    logic [PW-1:0]     r_pay   [0:NStg];

    assign r_valid[0] = i_valid;
    assign r_rad[0]   = i_rad;
    assign r_rem[0]   = '0;
    assign r_root[0]  = '0;
    assign r_pay[0]   = i_pay;

    for (genvar i = 0; i < NStg; i++) begin : g_stg
        logic [RemW-1:0] n_trem;
        logic [RemW-1:0] n_trial;
        logic            n_ge;

        // bring down two radicand bits and try the next root bit
        always_comb begin
            n_trem  = {r_rem[i][RemW-3:0], r_rad[i][RadW-1 -: 2]};
            n_trial = {3'b000, r_root[i], 2'b01};
            n_ge    = (n_trem >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[i+1] <= r_valid[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[i+1]  <= {r_rad[i][RadW-3:0], 2'b00};
                r_rem[i+1]  <= n_ge ? (n_trem - n_trial) : n_trem;
                r_root[i+1] <= {r_root[i][MagW-2:0], n_ge};
                r_pay[i+1]  <= r_pay[i];
            end
        end
    end

    assign o_valid = r_valid[NStg];
    assign o_root  = r_root[NStg];
    assign o_pay   = r_pay[NStg];

endmodule

[rtl/vmt_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on vmt_pkg; the quotient is known to stay below 2^MagW.
module vmt_div
    import vmt_pkg::*;
#(
    parameter int unsigned PW = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [NumW-1:0]    i_num,
    input  logic [MagW-1:0]    i_den,
    input  logic [PW-1:0]      i_pay,
    output logic               o_valid,
    output logic [MagW-1:0]    o_quo,
    output logic [PW-1:0]      o_pay
);

    localparam int unsigned NStg = MagW;
    localparam int unsigned RemW = MagW + 1;

    logic              r_valid [0:NStg];
    logic [RemW-1:0]   r_rem   [0:NStg];
    logic [MagW-1:0]   r_lo    [0:NStg];
    logic [MagW-1:0]   r_den   [0:NStg];
    logic [PW-1:0]     r_pay   [0:NStg];

    // high numerator bits already sit below the divisor
    assign r_valid[0] = i_valid;
    assign r_rem[0]   = {{(RemW-StepW){1'b0}}, i_num[NumW-1 -: StepW]};
    assign r_lo[0]    = i_num[MagW-1:0];
    assign r_den[0]   = i_den;
    assign r_pay[0]   = i_pay;

    for (genvar i = 0; i < NStg; i++) begin : g_stg
        logic [RemW-1:0] n_trem;
        logic [RemW-1:0] n_dext;
        logic            n_ge;

        // shift in one numerator bit, subtract where it fits
        always_comb begin
            n_trem = {r_rem[i][MagW-1:0], r_lo[i][MagW-1]};
            n_dext = {1'b0, r_den[i]};
            n_ge   = (n_trem >= n_dext);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[i+1] <= r_valid[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i+1] <= n_ge ? (n_trem - n_dext) : n_trem;
                r_lo[i+1]  <= {r_lo[i][MagW-2:0], n_ge};
                r_den[i+1] <= r_den[i];
                r_pay[i+1] <= r_pay[i];
            end
        end
    end

    assign o_valid = r_valid[NStg];
    assign o_quo   = r_lo[NStg];
    assign o_pay   = r_pay[NStg];

endmodule

[rtl/vector_move_towards.sv]
// Top level of the move-towards pipeline: difference, squares, square root,
// scale and divide. Depends on vmt_pkg, vmt_sqrt and vmt_div.
//
// Usage:
//   Input channel i_valid / o_stall carries the current point, the target
//   point and the largest step, all raw fixed point. Output channel
//   o_valid / i_stall returns the moved point and the reached flag.
//   One result per transaction, in order.
// Pipeline: the input register loads at the accepting edge; after it come
//   square, sum, 33 root stages, product, 33 divide stages and the output
//   register.
// Throughput: one transaction per cycle unless stalled; every stage is a
//   register with its own valid bit; square root and dividers fully pipelined.
// Stall: the whole pipeline holds while the output register is full and
//   i_stall is high; o_stall is raised in those cycles. Nothing is lost.
// Reset: synchronous, active low; all valid bits clear together, with
//   no clearing pass.
module vector_move_towards
    import vmt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [CoordW-1:0] i_current_x,
    input  logic signed [CoordW-1:0] i_current_y,
    input  logic signed [CoordW-1:0] i_target_x,
    input  logic signed [CoordW-1:0] i_target_y,
    input  logic [StepW-1:0]         i_max_step,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [CoordW-1:0] o_new_x,
    output logic signed [CoordW-1:0] o_new_y,
    output logic                     o_reached
);

    logic w_en;

    // advance everything unless a finished result is held
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // stage 1: input register
    logic              r_v1;
    logic signed [CoordW-1:0] r_cx, r_cy, r_tx, r_ty;
    logic [StepW-1:0]  r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cx   <= i_current_x;
            r_cy   <= i_current_y;
            r_tx   <= i_target_x;
            r_ty   <= i_target_y;
            r_step <= i_max_step;
        end
    end

    // stage 2: difference magnitudes and squares
    logic signed [MagW-1:0] n_dx, n_dy;
    logic [MagW-1:0]        n_adx, n_ady;

    always_comb begin
        n_dx  = {r_tx[CoordW-1], r_tx} - {r_cx[CoordW-1], r_cx};
        n_dy  = {r_ty[CoordW-1], r_ty} - {r_cy[CoordW-1], r_cy};
        n_adx = n_dx[MagW-1] ? MagW'(-n_dx) : MagW'(n_dx);
        n_ady = n_dy[MagW-1] ? MagW'(-n_dy) : MagW'(n_dy);
    end

    logic            r_v2;
    logic [RadW-1:0] r_sqx, r_sqy;
    t_sq_pay         r_pay2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sqx       <= n_adx * n_adx;
            r_sqy       <= n_ady * n_ady;
            r_pay2.adx  <= n_adx;
            r_pay2.ady  <= n_ady;
            r_pay2.sx   <= n_dx[MagW-1];
            r_pay2.sy   <= n_dy[MagW-1];
            r_pay2.cx   <= r_cx;
            r_pay2.cy   <= r_cy;
            r_pay2.tx   <= r_tx;
            r_pay2.ty   <= r_ty;
            r_pay2.step <= r_step;
        end
    end

    // stage 3: sum of squares
    logic            r_v3;
    logic [RadW-1:0] r_sum;
    t_sq_pay         r_pay3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum  <= r_sqx + r_sqy;
            r_pay3 <= r_pay2;
        end
    end

    // length by square root
    logic            w_sq_v;
    logic [MagW-1:0] w_len;
    t_sq_pay         w_sq_pay;

    vmt_sqrt #(
        .PW ($bits(t_sq_pay))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v3),
        .i_rad   (r_sum),
        .i_pay   (r_pay3),
        .o_valid (w_sq_v),
        .o_root  (w_len),
        .o_pay   (w_sq_pay)
    );

    // stage 4: reach test and scaled products
    logic            n_reached;
    logic            r_v4;
    logic [NumW-1:0] r_numx, r_numy;
    logic [MagW-1:0] r_len;
    t_dx_pay         r_payx;
    logic            r_sy4;

    assign n_reached = (w_len == '0) || (w_len <= {2'b00, w_sq_pay.step});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= w_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_numx          <= w_sq_pay.adx * w_sq_pay.step;
            r_numy          <= w_sq_pay.ady * w_sq_pay.step;
            // a zero length only occurs when reached; keep the divisor nonzero
            r_len           <= n_reached ? MagW'(1) : w_len;
            r_payx.reached  <= n_reached;
            r_payx.sx       <= w_sq_pay.sx;
            r_payx.cx       <= w_sq_pay.cx;
            r_payx.cy       <= w_sq_pay.cy;
            r_payx.tx       <= w_sq_pay.tx;
            r_payx.ty       <= w_sq_pay.ty;
            r_sy4           <= w_sq_pay.sy;
        end
    end

    // per-axis quotients
    logic            w_dx_v, w_dy_v;
    logic [MagW-1:0] w_qx, w_qy;
    t_dx_pay         w_px;
    logic            w_sy;

    vmt_div #(
        .PW ($bits(t_dx_pay))
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_num   (r_numx),
        .i_den   (r_len),
        .i_pay   (r_payx),
        .o_valid (w_dx_v),
        .o_quo   (w_qx),
        .o_pay   (w_px)
    );

    vmt_div #(
        .PW (1)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_num   (r_numy),
        .i_den   (r_len),
        .i_pay   (r_sy4),
        .o_valid (w_dy_v),
        .o_quo   (w_qy),
        .o_pay   (w_sy)
    );

    // stage out: apply signed offsets or pick the target
    logic [MagW-1:0] n_nx, n_ny;
    logic            r_out_v;

    always_comb begin
        n_nx = {w_px.cx[CoordW-1], w_px.cx} + (w_px.sx ? MagW'(-w_qx) : w_qx);
        n_ny = {w_px.cy[CoordW-1], w_px.cy} + (w_sy ? MagW'(-w_qy) : w_qy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_dx_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_new_x   <= w_px.reached ? w_px.tx : n_nx[CoordW-1:0];
            o_new_y   <= w_px.reached ? w_px.ty : n_ny[CoordW-1:0];
            o_reached <= w_px.reached;
        end
    end

    assign o_valid = r_out_v;

    // both dividers move in lockstep
    a_div_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dx_v == w_dy_v)
        else $error("divider valid bits disagree");

    // a held result stays put: valid, x and the reached flag are checked
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_new_x) && $stable(o_reached)))
        else $error("held result changed");

    // reset empties the output
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule
